[rtl/efs_pkg.sv]
// Shared types and constants for the per-EtherType frame statistics block.
`default_nettype none

package efs_pkg;

    localparam int MAC_W               = 48;
    localparam int TYPE_W              = 16;
    localparam int LEN_W               = 11;
    localparam int CNT_W               = 32;
    localparam int GROUP_BIT           = 40;
    localparam int DEFAULT_TABLE_DEPTH = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[rtl/ethertype_frame_statistics.sv]
// Per-EtherType frame and byte counters with sorted report, top level.
//
// Usage: pulse start with cmd = 0 to account one frame, cmd = 1 to report.
// busy is high while a command is in progress; a command is taken when start
// is high and busy is low. The table sits in a small memory that one
// sequencer walks one entry per cycle through a single compare unit, so an
// account command runs a full scan and then a write-back. A report runs
// one full scan per used entry to pick the next lowest EtherType before
// each emitted word, and an empty table skips the scan. Each report word
// appears for exactly one cycle with strobe high and the receiver cannot
// stall it; own_mac may be written only while busy is low.
`default_nettype none

module ethertype_frame_statistics #(
    parameter int TABLE_DEPTH = efs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [efs_pkg::MAC_W-1:0]   own_mac,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        cmd,
    input  wire logic [efs_pkg::MAC_W-1:0]   dest_mac,
    input  wire logic [efs_pkg::TYPE_W-1:0]  ether_type,
    input  wire logic [efs_pkg::LEN_W-1:0]   frame_length,
    output logic                             strobe,
    output logic                             entry_valid,
    output logic [efs_pkg::TYPE_W-1:0]       report_type,
    output logic [efs_pkg::CNT_W-1:0]        frame_count,
    output logic [efs_pkg::CNT_W-1:0]        byte_count,
    output logic [efs_pkg::CNT_W-1:0]        mine_count,
    output logic [efs_pkg::CNT_W-1:0]        multicast_count,
    output logic [efs_pkg::CNT_W-1:0]        dropped_count,
    output logic                             last
);
    import efs_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NUM_W = $clog2(TABLE_DEPTH + 1);

    // table memory
    logic [TYPE_W-1:0] mem_type   [0:TABLE_DEPTH-1];
    logic [CNT_W-1:0]  mem_frames [0:TABLE_DEPTH-1];
    logic [CNT_W-1:0]  mem_bytes  [0:TABLE_DEPTH-1];

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [TYPE_W-1:0] mem_wtype;
    logic [CNT_W-1:0]  mem_wframes;
    logic [CNT_W-1:0]  mem_wbytes;
    logic [IDX_W-1:0]  mem_raddr;

    logic [TYPE_W-1:0] rd_type_reg;
    logic [CNT_W-1:0]  rd_frames_reg;
    logic [CNT_W-1:0]  rd_bytes_reg;

    state_t state_reg, state_next;

    logic [MAC_W-1:0]       own_mac_reg;
    logic [TABLE_DEPTH-1:0] used_reg, used_next;
    logic [TABLE_DEPTH-1:0] done_reg, done_next;
    logic [NUM_W-1:0]       used_cnt_reg, used_cnt_next;
    logic [NUM_W-1:0]       emitted_reg, emitted_next;
    logic                   rpt_mode_reg, rpt_mode_next;

    logic [NUM_W-1:0]       idx_reg, idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;

    logic [TYPE_W-1:0]      key_type_reg, key_type_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   mine_hit_reg, mine_hit_next;
    logic                   mc_hit_reg, mc_hit_next;

    // selected entry: tag hit when accounting, running minimum when reporting
    logic                   sel_found_reg, sel_found_next;
    logic [IDX_W-1:0]       sel_idx_reg, sel_idx_next;
    logic [TYPE_W-1:0]      sel_type_reg, sel_type_next;
    logic [CNT_W-1:0]       sel_frames_reg, sel_frames_next;
    logic [CNT_W-1:0]       sel_bytes_reg, sel_bytes_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;

    logic [CNT_W-1:0]       mine_tot_reg, mine_tot_next;
    logic [CNT_W-1:0]       mc_tot_reg, mc_tot_next;
    logic [CNT_W-1:0]       drop_tot_reg, drop_tot_next;

    logic                   strobe_reg, strobe_next;
    logic                   out_valid_reg, out_valid_next;
    logic [TYPE_W-1:0]      out_type_reg, out_type_next;
    logic [CNT_W-1:0]       out_frames_reg, out_frames_next;
    logic [CNT_W-1:0]       out_bytes_reg, out_bytes_next;
    logic [CNT_W-1:0]       out_mine_reg, out_mine_next;
    logic [CNT_W-1:0]       out_mc_reg, out_mc_next;
    logic [CNT_W-1:0]       out_drop_reg, out_drop_next;
    logic                   out_last_reg, out_last_next;

    logic                   cur_used;
    logic                   type_eq;
    logic                   type_lt;
    logic                   is_last;

    assign mem_raddr = idx_reg[IDX_W-1:0];
    assign cur_used  = used_reg[cmp_idx_reg];
    assign type_eq   = (rd_type_reg == key_type_reg);
    assign type_lt   = (rd_type_reg < sel_type_reg);
    assign is_last   = !sel_found_reg || ((emitted_reg + NUM_W'(1)) == used_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_type[mem_waddr]   <= mem_wtype;
            mem_frames[mem_waddr] <= mem_wframes;
            mem_bytes[mem_waddr]  <= mem_wbytes;
        end
        rd_type_reg   <= mem_type[mem_raddr];
        rd_frames_reg <= mem_frames[mem_raddr];
        rd_bytes_reg  <= mem_bytes[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            own_mac_reg  <= '0;
            used_reg     <= '0;
            done_reg     <= '0;
            used_cnt_reg <= '0;
            emitted_reg  <= '0;
            rpt_mode_reg <= 1'b0;
            idx_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            key_type_reg <= '0;
            len_reg      <= '0;
            mine_hit_reg <= 1'b0;
            mc_hit_reg   <= 1'b0;
            sel_found_reg  <= 1'b0;
            sel_idx_reg    <= '0;
            sel_type_reg   <= '0;
            sel_frames_reg <= '0;
            sel_bytes_reg  <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            mine_tot_reg   <= '0;
            mc_tot_reg     <= '0;
            drop_tot_reg   <= '0;
            strobe_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_type_reg   <= '0;
            out_frames_reg <= '0;
            out_bytes_reg  <= '0;
            out_mine_reg   <= '0;
            out_mc_reg     <= '0;
            out_drop_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
            begin
                own_mac_reg <= own_mac;
            end
            used_reg     <= used_next;
            done_reg     <= done_next;
            used_cnt_reg <= used_cnt_next;
            emitted_reg  <= emitted_next;
            rpt_mode_reg <= rpt_mode_next;
            idx_reg      <= idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            cmp_idx_reg  <= cmp_idx_next;
            key_type_reg <= key_type_next;
            len_reg      <= len_next;
            mine_hit_reg <= mine_hit_next;
            mc_hit_reg   <= mc_hit_next;
            sel_found_reg  <= sel_found_next;
            sel_idx_reg    <= sel_idx_next;
            sel_type_reg   <= sel_type_next;
            sel_frames_reg <= sel_frames_next;
            sel_bytes_reg  <= sel_bytes_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            mine_tot_reg   <= mine_tot_next;
            mc_tot_reg     <= mc_tot_next;
            drop_tot_reg   <= drop_tot_next;
            strobe_reg     <= strobe_next;
            out_valid_reg  <= out_valid_next;
            out_type_reg   <= out_type_next;
            out_frames_reg <= out_frames_next;
            out_bytes_reg  <= out_bytes_next;
            out_mine_reg   <= out_mine_next;
            out_mc_reg     <= out_mc_next;
            out_drop_reg   <= out_drop_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        done_next       = done_reg;
        used_cnt_next   = used_cnt_reg;
        emitted_next    = emitted_reg;
        rpt_mode_next   = rpt_mode_reg;
        idx_next        = idx_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        key_type_next   = key_type_reg;
        len_next        = len_reg;
        mine_hit_next   = mine_hit_reg;
        mc_hit_next     = mc_hit_reg;
        sel_found_next  = sel_found_reg;
        sel_idx_next    = sel_idx_reg;
        sel_type_next   = sel_type_reg;
        sel_frames_next = sel_frames_reg;
        sel_bytes_next  = sel_bytes_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        mine_tot_next   = mine_tot_reg;
        mc_tot_next     = mc_tot_reg;
        drop_tot_next   = drop_tot_reg;
        strobe_next     = 1'b0;
        out_valid_next  = out_valid_reg;
        out_type_next   = out_type_reg;
        out_frames_next = out_frames_reg;
        out_bytes_next  = out_bytes_reg;
        out_mine_next   = out_mine_reg;
        out_mc_next     = out_mc_reg;
        out_drop_next   = out_drop_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = sel_idx_reg;
        mem_wtype       = key_type_reg;
        mem_wframes     = sel_frames_reg + CNT_W'(1);
        mem_wbytes      = sel_bytes_reg + CNT_W'(len_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_type_next   = ether_type;
                    len_next        = frame_length;
                    mine_hit_next   = (dest_mac == own_mac_reg);
                    mc_hit_next     = dest_mac[GROUP_BIT];
                    sel_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    idx_next        = '0;
                    rpt_mode_next   = cmd;
                    if (cmd && (used_cnt_reg == '0))
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle, compare it the cycle after
                if (idx_reg < NUM_W'(TABLE_DEPTH))
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[IDX_W-1:0];
                    idx_next     = idx_reg + NUM_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (rpt_mode_reg)
                    begin
                        if (cur_used && !done_reg[cmp_idx_reg] && (!sel_found_reg || type_lt))
                        begin
                            sel_found_next  = 1'b1;
                            sel_idx_next    = cmp_idx_reg;
                            sel_type_next   = rd_type_reg;
                            sel_frames_next = rd_frames_reg;
                            sel_bytes_next  = rd_bytes_reg;
                        end
                    end
                    else
                    begin
                        if (cur_used)
                        begin
                            if (!sel_found_reg && type_eq)
                            begin
                                sel_found_next  = 1'b1;
                                sel_idx_next    = cmp_idx_reg;
                                sel_frames_next = rd_frames_reg;
                                sel_bytes_next  = rd_bytes_reg;
                            end
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                    end
                    if (cmp_idx_reg == IDX_W'(TABLE_DEPTH - 1))
                    begin
                        state_next = rpt_mode_reg ? ST_EMIT : ST_UPDATE;
                    end
                end
            end

            ST_UPDATE:
            begin
                if (sel_found_reg)
                begin
                    mem_we = 1'b1;
                end
                else if (free_found_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = free_idx_reg;
                    mem_wframes = CNT_W'(1);
                    mem_wbytes  = CNT_W'(len_reg);
                    used_next[free_idx_reg] = 1'b1;
                    used_cnt_next = used_cnt_reg + NUM_W'(1);
                end
                else
                begin
                    drop_tot_next = drop_tot_reg + CNT_W'(1);
                end
                if (mine_hit_reg)
                begin
                    mine_tot_next = mine_tot_reg + CNT_W'(1);
                end
                if (mc_hit_reg)
                begin
                    mc_tot_next = mc_tot_reg + CNT_W'(1);
                end
                state_next = ST_IDLE;
            end

            ST_EMIT:
            begin
                strobe_next     = 1'b1;
                out_valid_next  = sel_found_reg;
                out_type_next   = sel_found_reg ? sel_type_reg : '0;
                out_frames_next = sel_found_reg ? sel_frames_reg : '0;
                out_bytes_next  = sel_found_reg ? sel_bytes_reg : '0;
                out_mine_next   = mine_tot_reg;
                out_mc_next     = mc_tot_reg;
                out_drop_next   = drop_tot_reg;
                out_last_next   = is_last;
                if (is_last)
                begin
                    used_next     = '0;
                    done_next     = '0;
                    used_cnt_next = '0;
                    emitted_next  = '0;
                    mine_tot_next = '0;
                    mc_tot_next   = '0;
                    drop_tot_next = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    done_next[sel_idx_reg] = 1'b1;
                    emitted_next   = emitted_reg + NUM_W'(1);
                    sel_found_next = 1'b0;
                    idx_next       = '0;
                    state_next     = ST_SCAN;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != ST_IDLE);
    assign strobe          = strobe_reg;
    assign entry_valid     = out_valid_reg;
    assign report_type     = out_type_reg;
    assign frame_count     = out_frames_reg;
    assign byte_count      = out_bytes_reg;
    assign mine_count      = out_mine_reg;
    assign multicast_count = out_mc_reg;
    assign dropped_count   = out_drop_reg;
    assign last            = out_last_reg;

endmodule

`default_nettype wire
